// ===== rtl/ite_pkg.sv =====
package ite_pkg;

   localparam int DATA_WIDTH  = 32;
   localparam int VALUE_WIDTH = 32;
   localparam int CNT_WIDTH   = $clog2(DATA_WIDTH);

   typedef logic [DATA_WIDTH-1:0] data_type;

   typedef enum logic [1:0] {
      CMD_NUMBER   = 2'd0,
      CMD_OPERATOR = 2'd1,
      CMD_END      = 2'd2,
      CMD_UNUSED   = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PEND_NONE = 2'd0,
      PEND_RSVD = 2'd1,
      PEND_MUL  = 2'd2,
      PEND_DIV  = 2'd3
   } pend_type;

   typedef struct packed {
      logic load_term;
      logic mul;
      logic join_term;
      logic sub;
      logic div_init;
      logic div_step;
      logic div_done;
      logic emit;
      logic err;
   } ite_cmd_type;

   typedef struct packed {
      logic div_last;
      logic out_busy;
   } ite_stat_type;

endpackage

// ===== rtl/ite_ctrl.sv =====
module ite_ctrl
   import ite_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic [1:0]   req_command,
   input  logic [1:0]   req_op_code,
   output logic         req_stall,
   output ite_cmd_type  cmd,
   input  ite_stat_type stat
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_RUN,
      ST_DIV_END,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      want_ff, want_in;
   pend_type  pend_ff, pend_in;
   logic      sign_ff, sign_in;
   logic      err_ff, err_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      want_in  = want_ff;
      pend_in  = pend_ff;
      sign_in  = sign_ff;
      err_in   = err_ff;
      cmd      = '0;
      cmd.sub  = sign_ff;
      cmd.err  = err_ff || want_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_NUMBER: begin
                     if (!want_ff) begin
                        err_in = 1'b1;
                     end else begin
                        want_in = 1'b0;
                        pend_in = PEND_NONE;
                        case (pend_ff)
                           PEND_MUL: cmd.mul = 1'b1;
                           PEND_DIV: begin
                              cmd.div_init = 1'b1;
                              state_in     = ST_DIV_RUN;
                           end
                           default: cmd.load_term = 1'b1;
                        endcase
                     end
                  end
                  CMD_OPERATOR: begin
                     if (want_ff) begin
                        err_in = 1'b1;
                     end else begin
                        want_in = 1'b1;
                        if (req_op_code inside {OP_ADD, OP_SUB}) begin
                           cmd.join_term = 1'b1;
                           sign_in       = (req_op_code == OP_SUB);
                           pend_in       = PEND_NONE;
                        end else if (req_op_code == OP_MUL) begin
                           pend_in = PEND_MUL;
                        end else begin
                           pend_in = PEND_DIV;
                        end
                     end
                  end
                  CMD_END: state_in = ST_EMIT;
                  default: ;
               endcase
            end
         end
         ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_DIV_END;
            end
         end
         ST_DIV_END: begin
            cmd.div_done = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_EMIT: begin
            if (!stat.out_busy) begin
               cmd.emit = 1'b1;
               want_in  = 1'b1;
               pend_in  = PEND_NONE;
               sign_in  = 1'b0;
               err_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         want_ff  <= 1'b1;
         pend_ff  <= PEND_NONE;
         sign_ff  <= 1'b0;
         err_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         want_ff  <= want_in;
         pend_ff  <= pend_in;
         sign_ff  <= sign_in;
         err_ff   <= err_in;
      end
   end

endmodule

// ===== rtl/ite_dp.sv =====
module ite_dp
   import ite_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   input  ite_cmd_type                   cmd,
   output ite_stat_type                  stat,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [VALUE_WIDTH-1:0] rsp_value_out,
   output logic                          rsp_error
);

   data_type               sum_ff, sum_in;
   data_type               term_ff, term_in;
   data_type               rem_ff, rem_in;
   data_type               quo_ff, quo_in;
   data_type               dsr_ff, dsr_in;
   logic                   neg_ff, neg_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                   rsp_error_ff, rsp_error_in;

   data_type               opnd;
   data_type               divisor;
   data_type               joined;
   logic [DATA_WIDTH:0]    shifted;
   logic                   fits;

   assign opnd    = DATA_WIDTH'(req_value);
   assign divisor = (opnd == '0) ? data_type'(1) : opnd;
   assign joined  = cmd.sub ? (sum_ff - term_ff) : (sum_ff + term_ff);
   assign shifted = {rem_ff, quo_ff[DATA_WIDTH-1]};
   assign fits    = (shifted >= {1'b0, dsr_ff});

   assign stat.div_last = (cnt_ff == CNT_WIDTH'(DATA_WIDTH - 1));
   assign stat.out_busy = rsp_valid_ff && rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_error     = rsp_error_ff;

   always_comb begin
      sum_in       = sum_ff;
      term_in      = term_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dsr_in       = dsr_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_error_in = rsp_error_ff;
      if (cmd.load_term) begin
         term_in = opnd;
      end
      if (cmd.mul) begin
         term_in = data_type'(term_ff * opnd);
      end
      if (cmd.join_term) begin
         sum_in  = joined;
         term_in = '0;
      end
      if (cmd.div_init) begin
         neg_in = term_ff[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
         quo_in = term_ff[DATA_WIDTH-1] ? (~term_ff + data_type'(1)) : term_ff;
         dsr_in = divisor[DATA_WIDTH-1] ? (~divisor + data_type'(1)) : divisor;
         rem_in = '0;
         cnt_in = '0;
      end
      if (cmd.div_step) begin
         rem_in = fits ? DATA_WIDTH'(shifted - {1'b0, dsr_ff})
                       : shifted[DATA_WIDTH-1:0];
         quo_in = {quo_ff[DATA_WIDTH-2:0], fits};
         cnt_in = cnt_ff + CNT_WIDTH'(1);
      end
      if (cmd.div_done) begin
         term_in = neg_ff ? (~quo_ff + data_type'(1)) : quo_ff;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = VALUE_WIDTH'($signed(joined));
         rsp_error_in = cmd.err;
         sum_in       = '0;
         term_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         term_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         term_ff      <= term_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      dsr_ff       <= dsr_in;
      neg_ff       <= neg_in;
      rsp_value_ff <= rsp_value_in;
      rsp_error_ff <= rsp_error_in;
   end

endmodule

// ===== rtl/infix_token_evaluator.sv =====
// infix expression evaluator, one token per transaction
// request channel: req_command (number, operator, end), req_value, req_op_code;
//    a transaction completes on req_valid high and req_stall low
// response channel: one transaction per end token, rsp_value_out and rsp_error
// multiply and divide bind tighter than add and subtract, left to right,
//    wrapping 32-bit arithmetic, division truncates toward zero, zero divisor
//    counts as one
// throughput: number and operator tokens are taken without a stall; a number
//    that follows a divide stalls the request channel while the shared
//    restoring divider makes one quotient bit per cycle, plus setup and sign
//    fix; an end token stalls it until the registered response is issued
// reset clears the running sum and term, the error flag and the response valid
//    flag; the first token must be a number
// while the receiver stalls, the response holds and further tokens are still
//    taken; a later end token is taken, its response waits for the held one
module infix_token_evaluator
   import ite_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_command,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   input  logic [1:0]                    req_op_code,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [VALUE_WIDTH-1:0] rsp_value_out,
   output logic                          rsp_error
);

   ite_cmd_type  cmd;
   ite_stat_type stat;

   ite_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_op_code (req_op_code),
      .req_stall   (req_stall),
      .cmd         (cmd),
      .stat        (stat)
   );

   ite_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value_out (rsp_value_out),
      .rsp_error     (rsp_error)
   );

endmodule

// ===== rtl/ite_checker.sv =====
module ite_checker
   import ite_pkg::*;
(
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [1:0]                    req_command,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [VALUE_WIDTH-1:0] rsp_value_out,
   input logic                          rsp_error
);

   logic req_take;

   assign req_take = req_valid && !req_stall;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value_out) && $stable(rsp_error))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_end_busy: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_command == CMD_END) |=> req_stall)
      else $error("end token did not hold off the request channel");

   a_op_single: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_command == CMD_OPERATOR || req_command == CMD_UNUSED) |=> !req_stall)
      else $error("operator token took more than one cycle");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response appeared without an end token");

endmodule

bind infix_token_evaluator ite_checker u_ite_checker (.*);

// ===== tb/infix_token_evaluator_test.sv =====
module infix_token_evaluator_test;
   import ite_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      command_type cmd;
      data_type    val;
      op_type      op;
      bit          typed;
      data_type    want_val;
      bit          want_err;
   } token_row_type;

   typedef struct packed {
      data_type value;
      logic     error;
   } expr_result_type;

   localparam data_type MOST_NEG = 32'h8000_0000;
   localparam data_type MOST_POS = 32'h7fff_ffff;
   localparam data_type MINUS_ONE = 32'hffff_ffff;

   // typed rows: empty expression, wrap on add, most negative over minus one,
   // zero divisor; the rest go through the predictor
   localparam token_row_type DIRECTED_ROWS [0:24] = '{
      '{CMD_END,      32'd0,      OP_ADD, 1'b1, 32'd0,    1'b1},
      '{CMD_NUMBER,   MOST_POS,   OP_ADD, 1'b0, 32'd0,    1'b0},
      '{CMD_OPERATOR, 32'd0,      OP_ADD, 1'b0, 32'd0,    1'b0},
      '{CMD_NUMBER,   32'd1,      OP_ADD, 1'b0, 32'd0,    1'b0},
      '{CMD_END,      32'd0,      OP_ADD, 1'b1, MOST_NEG, 1'b0},
      '{CMD_NUMBER,   MOST_NEG,   OP_ADD, 1'b0, 32'd0,    1'b0},
      '{CMD_OPERATOR, 32'd0,      OP_DIV, 1'b0, 32'd0,    1'b0},
      '{CMD_NUMBER,   MINUS_ONE,  OP_ADD, 1'b0, 32'd0,    1'b0},
      '{CMD_END,      32'd0,      OP_ADD, 1'b1, MOST_NEG, 1'b0},
      '{CMD_NUMBER,   32'd9,      OP_ADD, 1'b0, 32'd0,    1'b0},
      '{CMD_OPERATOR, 32'd0,      OP_DIV, 1'b0, 32'd0,    1'b0},
      '{CMD_NUMBER,   32'd0,      OP_ADD, 1'b0, 32'd0,    1'b0},
      '{CMD_END,      32'd0,      OP_ADD, 1'b1, 32'd9,    1'b0},
      '{CMD_NUMBER,   32'd3,      OP_ADD, 1'b0, 32'd0,    1'b0},
      '{CMD_NUMBER,   32'd4,      OP_ADD, 1'b0, 32'd0,    1'b0},
      '{CMD_OPERATOR, 32'd0,      OP_SUB, 1'b0, 32'd0,    1'b0},
      '{CMD_OPERATOR, 32'd0,      OP_MUL, 1'b0, 32'd0,    1'b0},
      '{CMD_UNUSED,   MINUS_ONE,  OP_DIV, 1'b0, 32'd0,    1'b0},
      '{CMD_NUMBER,   32'd10,     OP_ADD, 1'b0, 32'd0,    1'b0},
      '{CMD_OPERATOR, 32'd0,      OP_MUL, 1'b0, 32'd0,    1'b0},
      '{CMD_NUMBER,   32'hffff_fffe, OP_ADD, 1'b0, 32'd0, 1'b0},
      '{CMD_END,      32'd0,      OP_ADD, 1'b0, 32'd0,    1'b0},
      '{CMD_NUMBER,   32'hffff_fff9, OP_ADD, 1'b0, 32'd0, 1'b0},
      '{CMD_OPERATOR, 32'd0,      OP_MUL, 1'b0, 32'd0,    1'b0},
      '{CMD_END,      32'd0,      OP_ADD, 1'b0, 32'd0,    1'b0}
   };

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [1:0]                    req_command = CMD_NUMBER;
   logic signed [VALUE_WIDTH-1:0] req_value = '0;
   logic [1:0]                    req_op_code = OP_ADD;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [VALUE_WIDTH-1:0] rsp_value_out;
   logic                          rsp_error;

   // predictor state
   data_type run_sum;
   data_type run_term;
   bit       term_subtracts;
   pend_type pend;
   bit       need_number;
   bit       order_error;

   expr_result_type expr_results_due[$];
   bit              steady = 1'b0;
   int              tokens_sent = 0;
   int              divides_done = 0;
   int              results_checked = 0;
   int              error_results = 0;
   int              mismatches = 0;

   infix_token_evaluator i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_value     (req_value),
      .req_op_code   (req_op_code),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value_out (rsp_value_out),
      .rsp_error     (rsp_error)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("FAIL");
      $finish;
   end

   function automatic data_type quotient(data_type num, data_type den);
      data_type mag_num;
      data_type mag_den;
      data_type q;
      if (den == '0) den = 32'd1;
      mag_num = num[31] ? -num : num;
      mag_den = den[31] ? -den : den;
      q = mag_num / mag_den;
      return (num[31] ^ den[31]) ? -q : q;
   endfunction

   function automatic data_type joined_value();
      return term_subtracts ? run_sum - run_term : run_sum + run_term;
   endfunction

   function automatic void clear_state();
      run_sum = '0;
      run_term = '0;
      term_subtracts = 1'b0;
      pend = PEND_NONE;
      need_number = 1'b1;
      order_error = 1'b0;
   endfunction

   task automatic evaluate_token(input command_type cmd, input data_type val, input op_type op,
                                 output bit emits, output expr_result_type res);
      emits = 1'b0;
      res = '0;
      case (cmd)
         CMD_NUMBER: begin
            if (!need_number) begin
               order_error = 1'b1;
            end else begin
               case (pend)
                  PEND_MUL: run_term = run_term * val;
                  PEND_DIV: run_term = quotient(run_term, val);
                  default:  run_term = val;
               endcase
               pend = PEND_NONE;
               need_number = 1'b0;
            end
         end
         CMD_OPERATOR: begin
            if (need_number) begin
               order_error = 1'b1;
            end else begin
               if (op == OP_ADD || op == OP_SUB) begin
                  run_sum = joined_value();
                  run_term = '0;
                  term_subtracts = (op == OP_SUB);
                  pend = PEND_NONE;
               end else begin
                  pend = (op == OP_MUL) ? PEND_MUL : PEND_DIV;
               end
               need_number = 1'b1;
            end
         end
         CMD_END: begin
            emits = 1'b1;
            res.value = joined_value();
            res.error = order_error | need_number;
            clear_state();
         end
         default: ;
      endcase
   endtask

   task automatic send_token(input command_type cmd, input data_type val, input op_type op,
                             input bit typed, input data_type want_val, input bit want_err);
      bit              emits;
      expr_result_type res;
      while (!steady && $urandom_range(0, 99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_value <= val;
      req_op_code <= op;
      do @(posedge clock); while (req_stall);
      if (cmd == CMD_NUMBER && need_number && pend == PEND_DIV) divides_done++;
      evaluate_token(cmd, val, op, emits, res);
      if (emits) begin
         if (typed) begin
            res.value = want_val;
            res.error = want_err;
         end
         expr_results_due.push_back(res);
      end
      if (cmd != CMD_UNUSED) tokens_sent++;
      steady = (tokens_sent >= 200 && tokens_sent < 300);
   endtask

   function automatic data_type random_operand();
      case ($urandom_range(0, 9))
         0:       return MOST_NEG;
         1:       return MOST_POS;
         2:       return '0;
         3:       return MINUS_ONE;
         4, 5:    return data_type'($urandom_range(0, 20)) - 32'd10;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_number();
      send_token(CMD_NUMBER, random_operand(), op_type'($urandom_range(0, 3)), 1'b0, '0, 1'b0);
   endtask

   task automatic send_operator();
      send_token(CMD_OPERATOR, $urandom, op_type'($urandom_range(0, 3)), 1'b0, '0, 1'b0);
   endtask

   task automatic send_end();
      send_token(CMD_END, $urandom, op_type'($urandom_range(0, 3)), 1'b0, '0, 1'b0);
   endtask

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 19);
   end

   always @(posedge clock) begin
      expr_result_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expr_results_due.size() == 0) begin
            $display("%0t unexpected response: expected none, got value %0d error %0b",
                     $time, rsp_value_out, rsp_error);
            mismatches++;
         end else begin
            due = expr_results_due.pop_front();
            results_checked++;
            if (due.error) error_results++;
            if (rsp_value_out !== due.value) begin
               $display("%0t value_out mismatch: expected %0d, got %0d",
                        $time, $signed(due.value), rsp_value_out);
               mismatches++;
            end
            if (rsp_error !== due.error) begin
               $display("%0t error mismatch: expected %0b, got %0b",
                        $time, due.error, rsp_error);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int kind;
      int nums;
      clear_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_ROWS[i]) begin
         send_token(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].val, DIRECTED_ROWS[i].op,
                    DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want_val,
                    DIRECTED_ROWS[i].want_err);
      end

      while (tokens_sent < 450) begin
         kind = $urandom_range(0, 99);
         if (kind < 4) begin
            send_end();
         end else begin
            nums = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 4);
            for (int i = 0; i < nums; i++) begin
               if ($urandom_range(0, 9) == 0) begin
                  send_token(CMD_UNUSED, $urandom, op_type'($urandom_range(0, 3)),
                             1'b0, '0, 1'b0);
               end
               send_number();
               // out-of-order tokens
               if (kind < 10 && i == 0) send_number();
               if (i < nums - 1) begin
                  send_operator();
                  if (kind >= 10 && kind < 14 && i == 0) send_operator();
               end
            end
            // expression ends on an operator
            if (kind >= 14 && kind < 19) send_operator();
            send_end();
         end
      end
      req_valid <= 1'b0;

      while (expr_results_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("covered %0d tokens, %0d divides, %0d expressions checked (%0d with error set)",
               tokens_sent, divides_done, results_checked, error_results);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
